[sv/bis_pkg.sv]
// bis_pkg: shared types and constants of the bilinear image scaler
// used by bis_cfg, bis_interp and bilinear_image_scaler, depends on nothing
`default_nettype none

package bis_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_MAX_OUT    = 4096;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [15:0] RST_SCALE_X    = 16'd128;
    localparam logic [15:0] RST_SCALE_Y    = 16'd128;
    localparam logic [12:0] RST_OUT_WIDTH  = 13'd512;
    localparam logic [12:0] RST_OUT_HEIGHT = 13'd512;

    typedef enum logic {
        OP_LOAD    = 1'b0,
        OP_COMPUTE = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SIZE  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCALE_X    = 3'd0,
        CFG_SCALE_Y    = 3'd1,
        CFG_OUT_WIDTH  = 3'd2,
        CFG_OUT_HEIGHT = 3'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [15:0] scale_x;
        logic [15:0] scale_y;
        logic [12:0] out_width;
        logic [12:0] out_height;
    } t_cfg;

    // side information that travels with the four neighbour reads
    typedef struct packed {
        t_status    status;
        logic [7:0] fx;
        logic [7:0] fy;
        logic       col_par;
        logic       row_par;
    } t_tag;

endpackage

`default_nettype wire

[sv/bis_cfg.sv]
// bis_cfg: configuration registers of the scaler
// depends on bis_pkg
`default_nettype none

module bis_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [bis_pkg::CFG_IDX_W-1:0]  i_index,
    input  wire logic [bis_pkg::CFG_DATA_W-1:0] i_data,
    output bis_pkg::t_cfg                       o_cfg
);

    bis_pkg::t_cfg r_cfg;

    assign o_ready = 1'b1;
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.scale_x    <= bis_pkg::RST_SCALE_X;
            r_cfg.scale_y    <= bis_pkg::RST_SCALE_Y;
            r_cfg.out_width  <= bis_pkg::RST_OUT_WIDTH;
            r_cfg.out_height <= bis_pkg::RST_OUT_HEIGHT;
        end else if (i_valid) begin
            case (bis_pkg::t_cfg_idx'(i_index))
                bis_pkg::CFG_SCALE_X:    r_cfg.scale_x    <= i_data;
                bis_pkg::CFG_SCALE_Y:    r_cfg.scale_y    <= i_data;
                bis_pkg::CFG_OUT_WIDTH:  r_cfg.out_width  <= i_data[12:0];
                bis_pkg::CFG_OUT_HEIGHT: r_cfg.out_height <= i_data[12:0];
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire

[sv/bis_bank.sv]
// bis_bank: one parity bank of the source image, simple dual port
// registered read, no dependencies
`default_nettype none

module bis_bank #(
    parameter int AW = 18
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [7:0]    i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [7:0]    o_rdata
);

    logic [7:0] r_mem [2**AW];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

[sv/bis_interp.sv]
// bis_interp: weighting pipeline, from four neighbour pixels to the result
// depends on bis_pkg
`default_nettype none

module bis_interp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire bis_pkg::t_tag   i_tag,
    input  wire logic [3:0][7:0] i_pix,
    output logic                 o_valid,
    input  wire logic            i_stall,
    output logic      [7:0]      o_pixel,
    output logic      [1:0]      o_status
);

    logic             rdy_o;
    logic             rdy5;
    logic             rdy4;
    logic [7:0]       p00;
    logic [7:0]       p01;
    logic [7:0]       p10;
    logic [7:0]       p11;
    logic [7:0]       gx;
    logic [16:0]      n_a4;
    logic [16:0]      n_b4;
    logic [24:0]      n_ta5;
    logic [24:0]      n_tb5;
    logic [9:0]       n_sum;

    logic             r_v4;
    logic [16:0]      r_a4;
    logic [16:0]      r_b4;
    logic [7:0]       r_fy4;
    bis_pkg::t_status r_st4;
    logic             r_v5;
    logic [24:0]      r_ta5;
    logic [24:0]      r_tb5;
    bis_pkg::t_status r_st5;
    logic             r_ov;
    logic [7:0]       r_opix;
    bis_pkg::t_status r_ost;

    assign rdy_o   = !r_ov || !i_stall;
    assign rdy5    = !r_v5 || rdy_o;
    assign rdy4    = !r_v4 || rdy5;
    assign o_ready = !i_valid || rdy4;

    // bank index is {row parity, column parity}
    always_comb begin
        p00   = i_pix[{i_tag.row_par, i_tag.col_par}];
        p01   = i_pix[{i_tag.row_par, ~i_tag.col_par}];
        p10   = i_pix[{~i_tag.row_par, i_tag.col_par}];
        p11   = i_pix[{~i_tag.row_par, ~i_tag.col_par}];
        gx    = 8'hff - i_tag.fx;
        n_a4  = 17'(p00) * 17'(gx) + 17'(p01) * 17'(i_tag.fx);
        n_b4  = 17'(p10) * 17'(gx) + 17'(p11) * 17'(i_tag.fx);
        n_ta5 = 25'(r_a4) * 25'(8'hff - r_fy4);
        n_tb5 = 25'(r_b4) * 25'(r_fy4);
        n_sum = 10'(r_ta5[24:16]) + 10'(r_tb5[24:16]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rdy4) begin
                r_v4 <= i_valid;
            end
            if (rdy5) begin
                r_v5 <= r_v4;
            end
            if (rdy_o) begin
                r_ov <= r_v5;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy4 && i_valid) begin
            r_a4  <= n_a4;
            r_b4  <= n_b4;
            r_fy4 <= i_tag.fy;
            r_st4 <= i_tag.status;
        end
        if (rdy5 && r_v4) begin
            r_ta5 <= n_ta5;
            r_tb5 <= n_tb5;
            r_st5 <= r_st4;
        end
        if (rdy_o && r_v5) begin
            r_opix <= (r_st5 == bis_pkg::ST_OK) ? n_sum[7:0] : 8'd0;
            r_ost  <= r_st5;
        end
    end

    assign o_valid  = r_ov;
    assign o_pixel  = r_opix;
    assign o_status = r_ost;

endmodule

`default_nettype wire

[sv/bilinear_image_scaler.sv]
// bilinear_image_scaler: one request per cycle while o_in_stall is low
// the four neighbours come from four parity banks read in the same cycle, so rate is set by
// the pipeline alone; loads write in the same stage that computes read, keeping order
// reset clears the pipeline and sets the registers; the image memory is not cleared
// depends on bis_pkg, bis_cfg, bis_bank, bis_interp
`default_nettype none

module bilinear_image_scaler #(
    parameter int MAX_WIDTH  = bis_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bis_pkg::DEF_MAX_HEIGHT,
    parameter int MAX_OUT    = bis_pkg::DEF_MAX_OUT
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic                           i_operation,
    input  wire logic [9:0]                     i_src_col,
    input  wire logic [9:0]                     i_src_row,
    input  wire logic [7:0]                     i_src_pixel,
    input  wire logic [11:0]                    i_out_col,
    input  wire logic [11:0]                    i_out_row,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic [7:0]                          o_out_pixel,
    output logic [1:0]                          o_status
);

    localparam int HCOL = (MAX_WIDTH + 1) / 2;
    localparam int HROW = (MAX_HEIGHT + 1) / 2;
    localparam int CHB  = (HCOL > 1) ? $clog2(HCOL) : 1;
    localparam int RHB  = (HROW > 1) ? $clog2(HROW) : 1;
    localparam int AW   = CHB + RHB;

    bis_pkg::t_cfg    cfg;

    logic             rdy1;
    logic             rdy2;
    logic             rdy3;
    logic             adv2;

    logic             r_v1;
    bis_pkg::t_op     r_op1;
    logic [9:0]       r_scol1;
    logic [9:0]       r_srow1;
    logic [7:0]       r_spix1;
    logic [11:0]      r_ocol1;
    logic [11:0]      r_orow1;

    logic [27:0]      n_x2;
    logic [27:0]      n_y2;
    logic             n_serr2;
    logic             r_v2;
    bis_pkg::t_op     r_op2;
    logic [9:0]       r_scol2;
    logic [9:0]       r_srow2;
    logic [7:0]       r_spix2;
    logic [27:0]      r_x2;
    logic [27:0]      r_y2;
    logic             r_serr2;

    logic [19:0]      nx;
    logic [19:0]      ny;
    logic             range_err;
    logic             ld_ok;
    logic [20:0]      colh_lo;
    logic [20:0]      colh_hi;
    logic [20:0]      rowh_lo;
    logic [20:0]      rowh_hi;
    logic [13:0]      ld_colh;
    logic [13:0]      ld_rowh;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr [4];
    logic [3:0]       bank_we;
    logic             bank_re;
    logic [3:0][7:0]  bank_q;
    bis_pkg::t_tag    n_tag3;

    logic             r_v3;
    bis_pkg::t_tag    r_tag3;

    logic [16:0]      lim_w;
    logic [16:0]      lim_h;

    bis_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cfg_valid),
        .o_ready (o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    // stage 1: size check and source coordinates
    assign rdy1       = !r_v1 || rdy2;
    assign o_in_stall = !rdy1;

    always_comb begin
        lim_w   = (17'(cfg.out_width) > 17'(MAX_OUT)) ? 17'(MAX_OUT) : 17'(cfg.out_width);
        lim_h   = (17'(cfg.out_height) > 17'(MAX_OUT)) ? 17'(MAX_OUT) : 17'(cfg.out_height);
        n_serr2 = (17'(r_ocol1) >= lim_w) || (17'(r_orow1) >= lim_h);
        n_x2    = 28'(r_ocol1) * 28'(cfg.scale_x);
        n_y2    = 28'(r_orow1) * 28'(cfg.scale_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_in_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2 && (r_op2 == bis_pkg::OP_COMPUTE);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_in_valid) begin
            r_op1   <= bis_pkg::t_op'(i_operation);
            r_scol1 <= i_src_col;
            r_srow1 <= i_src_row;
            r_spix1 <= i_src_pixel;
            r_ocol1 <= i_out_col;
            r_orow1 <= i_out_row;
        end
        if (rdy2 && r_v1) begin
            r_op2   <= r_op1;
            r_scol2 <= r_scol1;
            r_srow2 <= r_srow1;
            r_spix2 <= r_spix1;
            r_x2    <= n_x2;
            r_y2    <= n_y2;
            r_serr2 <= n_serr2;
        end
        if (bank_re) begin
            r_tag3 <= n_tag3;
        end
    end

    // stage 2: neighbour check, bank addresses, loads write here
    assign rdy2 = !r_v2 || (r_op2 == bis_pkg::OP_LOAD) || rdy3;
    assign adv2 = r_v2 && rdy2;

    always_comb begin
        nx        = r_x2[27:8];
        ny        = r_y2[27:8];
        range_err = ((21'(nx) + 21'd1) >= 21'(MAX_WIDTH)) ||
                    ((21'(ny) + 21'd1) >= 21'(MAX_HEIGHT));
        colh_lo   = (21'(nx) + 21'd1) >> 1;
        colh_hi   = 21'(nx) >> 1;
        rowh_lo   = (21'(ny) + 21'd1) >> 1;
        rowh_hi   = 21'(ny) >> 1;
        raddr[0]  = {rowh_lo[RHB-1:0], colh_lo[CHB-1:0]};
        raddr[1]  = {rowh_lo[RHB-1:0], colh_hi[CHB-1:0]};
        raddr[2]  = {rowh_hi[RHB-1:0], colh_lo[CHB-1:0]};
        raddr[3]  = {rowh_hi[RHB-1:0], colh_hi[CHB-1:0]};

        ld_ok   = (14'(r_scol2) < 14'(MAX_WIDTH)) && (14'(r_srow2) < 14'(MAX_HEIGHT));
        ld_colh = 14'(r_scol2) >> 1;
        ld_rowh = 14'(r_srow2) >> 1;
        waddr   = {ld_rowh[RHB-1:0], ld_colh[CHB-1:0]};

        bank_re = adv2 && (r_op2 == bis_pkg::OP_COMPUTE);
        for (int b = 0; b < 4; b++) begin
            bank_we[b] = adv2 && (r_op2 == bis_pkg::OP_LOAD) && ld_ok &&
                         (r_scol2[0] == 1'(b % 2)) && (r_srow2[0] == 1'(b / 2));
        end

        n_tag3.status  = r_serr2 ? bis_pkg::ST_SIZE :
                         (range_err ? bis_pkg::ST_RANGE : bis_pkg::ST_OK);
        n_tag3.fx      = r_x2[7:0];
        n_tag3.fy      = r_y2[7:0];
        n_tag3.col_par = nx[0];
        n_tag3.row_par = ny[0];
    end

    for (genvar g = 0; g < 4; g++) begin : g_bank
        bis_bank #(
            .AW (AW)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (bank_we[g]),
            .i_waddr (waddr),
            .i_wdata (r_spix2),
            .i_re    (bank_re),
            .i_raddr (raddr[g]),
            .o_rdata (bank_q[g])
        );
    end

    // stage 3 onward: weighting and result register
    bis_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_v3),
        .o_ready  (rdy3),
        .i_tag    (r_tag3),
        .i_pix    (bank_q),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_pixel  (o_out_pixel),
        .o_status (o_status)
    );

    a_load_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && (r_op2 == bis_pkg::OP_LOAD) && rdy3) |=> !r_v3)
        else $error("load request entered the read stage");

    a_one_bank_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(bank_we))
        else $error("more than one bank written");

    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !((|bank_we) && bank_re))
        else $error("bank read and write in the same cycle");

    a_read_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !rdy3) |=> (r_v3 && $stable(r_tag3)))
        else $error("stalled read stage lost its request");

endmodule

`default_nettype wire
